/* rtl/jddm_pkg.sv */
// shared types, constants and register codes of the joystick drive mixer
// no dependencies; imported by every module of the block
package jddm_pkg;

  // field widths
  localparam int SAMPLE_W    = 12;
  localparam int DEADZONE_W  = 7;
  localparam int DRIVE_W     = 8;
  localparam int SEQ_W       = 8;

  // group length default (range 1 to 16)
  localparam int SAMPLES_DEF = 4;

  // queue between accumulator and shaping unit
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE    = 4'd0,
    CFG_CENTER_X    = 4'd1,
    CFG_CENTER_Y    = 4'd2,
    CFG_EXPO_ENABLE = 4'd3
  } cfg_index_t;

  // register reset values
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST = 7'd10;
  localparam logic [SAMPLE_W-1:0]   CENTER_RST   = 12'd2048;
  localparam logic                  EXPO_RST     = 1'b1;

  // axis scaling constants
  localparam int AXIS_MAX  = 127;
  localparam int POS_DIV   = 2047;
  localparam int NEG_OFF   = 2048;
  localparam int NEG_SH    = 11;
  localparam int CENTRED_W = SAMPLE_W + 1;
  localparam int P_W       = 19;
  localparam int SHAPED_W  = 10;
  localparam int MAG_W     = 8;
  localparam int SQR_W     = 16;
  localparam int MIX_W     = 11;

  // reciprocal of 2047 for products below 2^19, exact after the shift
  localparam int SCALE_SH  = P_W + NEG_SH;
  localparam int SCALE_MW  = 20;
  localparam longint unsigned SCALE_M =
    ((64'd1 << SCALE_SH) + POS_DIV - 1) / POS_DIV;
  localparam int SCALE_PW  = P_W + SCALE_MW;

  // reciprocal of 127 for squares below 2^16
  localparam int EXPO_SH   = SQR_W + 7;
  localparam int EXPO_MW   = 17;
  localparam longint unsigned EXPO_M =
    ((64'd1 << EXPO_SH) + AXIS_MAX - 1) / AXIS_MAX;
  localparam int EXPO_PW   = SQR_W + EXPO_MW;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic [SEQ_W-1:0]          sequence_res;
  } out_t;

  typedef struct packed {
    logic [DEADZONE_W-1:0] deadzone;
    logic [SAMPLE_W-1:0]   center_x;
    logic [SAMPLE_W-1:0]   center_y;
    logic                  expo_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CENTRE,
    ST_SCALE,
    ST_SHAPE,
    ST_SQUARE,
    ST_EXPO,
    ST_MIX
  } back_state_t;

endpackage

/* rtl/joystick_differential_drive_mixer_core.sv */
// top level of the joystick differential drive mixer
// depends on jddm_pkg, jddm_front, jddm_fifo and jddm_back
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    in_data   (sample_x, sample_y)
// out       source     out_valid / out_ready  out_data  (left, right, sequence_res)
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the accumulator takes one sample pair per cycle while in_ready is high; every
// SAMPLES pairs it pushes the group sums into a two-entry queue
// the shaping unit takes one group at a time in steps (pop, average, centre, scale,
// shape, square, expo, mix), and pops the next group only once a result is loaded
// when the queue is full in_ready drops on the last pair of a group
// a finished result sits in the output register while the next group is shaped
// rst is synchronous and clears sums, counters, queue and configuration registers to defaults
module joystick_differential_drive_mixer_core #(
  parameter int SAMPLES = jddm_pkg::SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  jddm_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output jddm_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jddm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import jddm_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
  localparam int GRP_W = 2 * SUM_W;

  cfg_t cfg;

  logic             grp_valid, grp_ready;
  logic [SUM_W-1:0] grp_sum_x, grp_sum_y;
  logic             q_valid, q_ready;
  logic [GRP_W-1:0] q_data;

  // configuration registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone    <= DEADZONE_RST;
      cfg.center_x    <= CENTER_RST;
      cfg.center_y    <= CENTER_RST;
      cfg.expo_enable <= EXPO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEADZONE:    cfg.deadzone    <= cfg_data[DEADZONE_W-1:0];
        CFG_CENTER_X:    cfg.center_x    <= cfg_data[SAMPLE_W-1:0];
        CFG_CENTER_Y:    cfg.center_y    <= cfg_data[SAMPLE_W-1:0];
        CFG_EXPO_ENABLE: cfg.expo_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: group accumulation
  jddm_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_sum_x (grp_sum_x),
    .grp_sum_y (grp_sum_y)
  );

  // queue of completed group sums
  jddm_fifo #(
    .WIDTH (GRP_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (grp_valid),
    .push_ready (grp_ready),
    .push_data  ({grp_sum_x, grp_sum_y}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back: shaping, mixing and result register
  jddm_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_sum_x   (q_data[GRP_W-1:SUM_W]),
    .q_sum_y   (q_data[SUM_W-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/jddm_front.sv */
// accumulator: sums sample pairs and hands each completed group to the queue
// depends on jddm_pkg
module jddm_front #(
  parameter int SAMPLES = jddm_pkg::SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jddm_pkg::in_t       in_data,
  output logic                grp_valid,
  input  logic                grp_ready,
  output logic [jddm_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] grp_sum_x,
  output logic [jddm_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] grp_sum_y
);
  import jddm_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [SUM_W-1:0] sum_x, sum_y, sum_x_next, sum_y_next;
  logic [CNT_W-1:0] samples_taken;
  logic             last, accept;

  assign last       = (samples_taken == CNT_W'(SAMPLES - 1));
  assign in_ready   = !last || grp_ready;
  assign accept     = in_valid && in_ready;
  assign sum_x_next = sum_x + SUM_W'(in_data.sample_x);
  assign sum_y_next = sum_y + SUM_W'(in_data.sample_y);

  // the last pair of a group goes straight into the queue with the sums
  assign grp_valid  = in_valid && last;
  assign grp_sum_x  = sum_x_next;
  assign grp_sum_y  = sum_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (last) begin
        sum_x         <= '0;
        sum_y         <= '0;
        samples_taken <= '0;
      end else begin
        sum_x         <= sum_x_next;
        sum_y         <= sum_y_next;
        samples_taken <= samples_taken + 1'b1;
      end
    end
  end

endmodule

/* rtl/jddm_fifo.sv */
// short queue of group sums between the accumulator and the shaping unit
// depends on jddm_pkg
module jddm_fifo #(
  parameter int WIDTH = 2 * (jddm_pkg::SAMPLE_W + $clog2(jddm_pkg::SAMPLES_DEF))
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import jddm_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/jddm_back.sv */
// shaping unit: averages, centres, scales, applies deadzone and optional expo, mixes
// depends on jddm_pkg; one group at a time through a step sequencer
module jddm_back #(
  parameter int SAMPLES = jddm_pkg::SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  jddm_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [jddm_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] q_sum_x,
  input  logic [jddm_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] q_sum_y,
  output logic           out_valid,
  input  logic           out_ready,
  output jddm_pkg::out_t out_data
);
  import jddm_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLES);
  localparam int AVG_L  = $clog2(SAMPLES);
  localparam int AVG_SH = SUM_W + AVG_L;
  localparam int AVG_MW = SUM_W + 1;
  localparam longint unsigned AVG_M =
    ((64'd1 << AVG_SH) + SAMPLES - 1) / SAMPLES;
  localparam int AVG_PW = SUM_W + AVG_MW;
  localparam int LANES  = 2;

  back_state_t state, state_next;
  logic        load;
  logic [SEQ_W-1:0] packet_count;

  // per-lane registers, lane 0 is x and lane 1 is y
  logic [SUM_W-1:0]           sum_r      [LANES];
  logic [AVG_PW-1:0]          avg_prod   [LANES];
  logic                       pos_r      [LANES];
  logic                       negw_r     [LANES];
  logic [P_W-1:0]             prod127    [LANES];
  logic [SCALE_PW-1:0]        scale_prod [LANES];
  logic signed [SHAPED_W-1:0] shaped     [LANES];
  logic [MAG_W-1:0]           mag_r      [LANES];
  logic [SQR_W-1:0]           sqr        [LANES];
  logic [EXPO_PW-1:0]         expo_prod  [LANES];

  // per-lane combinational values
  logic [SAMPLE_W-1:0]         centre   [LANES];
  logic [SAMPLE_W-1:0]         avg      [LANES];
  logic signed [CENTRED_W-1:0] centred  [LANES];
  logic signed [CENTRED_W-1:0] shifted  [LANES];
  logic [SAMPLE_W-1:0]         opnd     [LANES];
  logic signed [SHAPED_W-1:0]  s_pos    [LANES];
  logic signed [SHAPED_W-1:0]  s_neg    [LANES];
  logic signed [SHAPED_W-1:0]  s_val    [LANES];
  logic [MAG_W-1:0]            s_mag    [LANES];
  logic                        dead     [LANES];
  logic signed [MIX_W-1:0]     sq       [LANES];
  logic signed [MIX_W-1:0]     curved   [LANES];
  logic signed [DRIVE_W-1:0]   axis_val [LANES];
  logic signed [MIX_W-1:0]     mix_l, mix_r;

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [MIX_W-1:0] v
  );
    if (v > MIX_W'(AXIS_MAX)) begin
      return DRIVE_W'(AXIS_MAX);
    end else if (v < -MIX_W'(AXIS_MAX)) begin
      return -DRIVE_W'(AXIS_MAX);
    end else begin
      return DRIVE_W'(v);
    end
  endfunction

  assign centre[0] = cfg.center_x;
  assign centre[1] = cfg.center_y;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      avg[i]     = avg_prod[i][AVG_SH +: SAMPLE_W];
      centred[i] = $signed({1'b0, avg[i]}) - $signed({1'b0, centre[i]});
      shifted[i] = centred[i] + CENTRED_W'(NEG_OFF);
      if (centred[i] > 0) begin
        opnd[i] = centred[i][SAMPLE_W-1:0];
      end else if (shifted[i] < 0) begin
        opnd[i] = SAMPLE_W'(-shifted[i]);
      end else begin
        opnd[i] = shifted[i][SAMPLE_W-1:0];
      end
      // positive side: product over 2047 through the reciprocal
      s_pos[i] = $signed({2'b00, scale_prod[i][SCALE_SH +: MAG_W]});
      // other side: truncating divide by 2048 then the offset
      s_neg[i] = (negw_r[i] ? -$signed({2'b00, prod127[i][NEG_SH +: MAG_W]})
                            :  $signed({2'b00, prod127[i][NEG_SH +: MAG_W]}))
                 - SHAPED_W'(AXIS_MAX);
      s_val[i] = pos_r[i] ? s_pos[i] : s_neg[i];
      s_mag[i] = (s_val[i] < 0) ? MAG_W'(-s_val[i]) : MAG_W'(s_val[i]);
      dead[i]  = (s_mag[i] < MAG_W'(cfg.deadzone));
      // expo and final axis clamp
      sq[i]     = $signed({2'b00, expo_prod[i][EXPO_SH +: MIX_W-2]});
      if (cfg.expo_enable) begin
        curved[i] = (shaped[i] < 0) ? -sq[i] : sq[i];
      end else begin
        curved[i] = MIX_W'(shaped[i]);
      end
      axis_val[i] = clamp_drive(curved[i]);
    end
    mix_l = MIX_W'(axis_val[1]) + MIX_W'(axis_val[0]);
    mix_r = MIX_W'(axis_val[1]) - MIX_W'(axis_val[0]);
  end

  // next state
  always_comb begin
    case (state)
      ST_IDLE:   state_next = q_valid ? ST_AVG : ST_IDLE;
      ST_AVG:    state_next = ST_CENTRE;
      ST_CENTRE: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SHAPE;
      ST_SHAPE:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_EXPO;
      ST_EXPO:   state_next = ST_MIX;
      ST_MIX:    state_next = load ? ST_IDLE : ST_MIX;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_ready = 1'b0;
    load    = 1'b0;
    case (state)
      ST_IDLE: q_ready = 1'b1;
      ST_MIX:  load    = !out_valid || out_ready;
      default: begin
        q_ready = 1'b0;
        load    = 1'b0;
      end
    endcase
  end

  // datapath steps, one register after every multiply
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          sum_r[0] <= q_sum_x;
          sum_r[1] <= q_sum_y;
        end
      end
      ST_AVG: begin
        for (int i = 0; i < LANES; i++) begin
          avg_prod[i] <= AVG_PW'(sum_r[i]) * AVG_PW'(AVG_M);
        end
      end
      ST_CENTRE: begin
        for (int i = 0; i < LANES; i++) begin
          pos_r[i]   <= (centred[i] > 0);
          negw_r[i]  <= (shifted[i] < 0);
          prod127[i] <= P_W'(opnd[i]) * P_W'(AXIS_MAX);
        end
      end
      ST_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          scale_prod[i] <= SCALE_PW'(prod127[i]) * SCALE_PW'(SCALE_M);
        end
      end
      ST_SHAPE: begin
        for (int i = 0; i < LANES; i++) begin
          shaped[i] <= dead[i] ? '0 : s_val[i];
          mag_r[i]  <= dead[i] ? '0 : s_mag[i];
        end
      end
      ST_SQUARE: begin
        for (int i = 0; i < LANES; i++) begin
          sqr[i] <= SQR_W'(mag_r[i]) * SQR_W'(mag_r[i]);
        end
      end
      ST_EXPO: begin
        for (int i = 0; i < LANES; i++) begin
          expo_prod[i] <= EXPO_PW'(sqr[i]) * EXPO_PW'(EXPO_M);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.left_drive   <= clamp_drive(mix_l);
      out_data.right_drive  <= clamp_drive(mix_r);
      out_data.sequence_res <= packet_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      packet_count <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid    <= 1'b1;
        packet_count <= packet_count + 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && q_valid) |=> (state == ST_AVG))
    else $error("group popped but sequencer did not start");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && out_data.sequence_res == $past(packet_count)))
    else $error("result not presented with its packet number");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    load |=> (packet_count == $past(packet_count) + 1'b1))
    else $error("packet number did not advance by one");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.left_drive != -8'sd128 &&
                   out_data.right_drive != -8'sd128))
    else $error("drive value outside the clamp range");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for joystick_differential_drive_mixer_core: directed groups, then
// phases of random sample groups under several register settings; needs jddm_pkg and the rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jddm_pkg::*;

  localparam int GROUP        = SAMPLES_DEF;
  localparam int SUM_W        = SAMPLE_W + $clog2(GROUP);
  localparam int SETTLE       = 32;   // cycles to let the shaping pipe empty
  localparam int REPORT_MAX   = 10;
  localparam int PHASE_GROUPS = 61;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

  // how the stimulus picks the level of an axis for one group
  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_RAIL, SPREAD_EDGE} spread_t;
  // how the result side holds off
  typedef enum int {STALL_NONE, STALL_RUNS, STALL_SCATTER} stall_t;

  // shadow of the mixer: registers, group sums and the packets still owed
  class drive_mix_scoreboard;
    logic [DEADZONE_W-1:0] deadzone;
    logic [SAMPLE_W-1:0]   center_x;
    logic [SAMPLE_W-1:0]   center_y;
    logic                  expo_enable;
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;
    int                    taken;
    logic [SEQ_W-1:0]      packet_no;
    out_t                  drive_queue[$];
    int                    results;
    int                    failures;

    function new();
      deadzone    = DEADZONE_RST;
      center_x    = CENTER_RST;
      center_y    = CENTER_RST;
      expo_enable = EXPO_RST;
      sum_x       = '0;
      sum_y       = '0;
      taken       = 0;
      packet_no   = '0;
      results     = 0;
      failures    = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEADZONE:    deadzone    = data[DEADZONE_W-1:0];
        CFG_CENTER_X:    center_x    = data[SAMPLE_W-1:0];
        CFG_CENTER_Y:    center_y    = data[SAMPLE_W-1:0];
        CFG_EXPO_ENABLE: expo_enable = data[0];
        default: ;
      endcase
    endfunction

    function int clamp_drive(int v);
      if (v > AXIS_MAX) return AXIS_MAX;
      if (v < -AXIS_MAX) return -AXIS_MAX;
      return v;
    endfunction

    // centre, scale, deadzone, optional square curve, clamp
    function int shape_stick_axis(logic [SAMPLE_W-1:0] avg, logic [SAMPLE_W-1:0] centre);
      int v;
      int mag;
      int sq;
      v = int'(avg) - int'(centre);
      if (v > 0) v = (v * AXIS_MAX) / POS_DIV;
      else v = ((v + NEG_OFF) * AXIS_MAX) / NEG_OFF - AXIS_MAX;
      mag = (v < 0) ? -v : v;
      if (mag < int'(deadzone)) v = 0;
      if (expo_enable && v != 0) begin
        sq = (mag * mag) / AXIS_MAX;
        v = (v < 0) ? -sq : sq;
      end
      return clamp_drive(v);
    endfunction

    function void note_input(in_t pair);
      out_t want;
      int x;
      int y;
      sum_x += pair.sample_x;
      sum_y += pair.sample_y;
      taken++;
      if (taken < GROUP) return;
      x = shape_stick_axis(SAMPLE_W'(sum_x / GROUP), center_x);
      y = shape_stick_axis(SAMPLE_W'(sum_y / GROUP), center_y);
      want.left_drive   = DRIVE_W'(clamp_drive(y + x));
      want.right_drive  = DRIVE_W'(clamp_drive(y - x));
      want.sequence_res = packet_no;
      drive_queue.push_back(want);
      packet_no++;
      sum_x = '0;
      sum_y = '0;
      taken = 0;
    endfunction

    function void check_result(out_t got);
      out_t want;
      results++;
      if (drive_queue.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected drive beat: left %0d right %0d seq %0d",
                   got.left_drive, got.right_drive, got.sequence_res);
        return;
      end
      want = drive_queue.pop_front();
      if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
          got.sequence_res !== want.sequence_res) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("drive mismatch: expected left %0d right %0d seq %0d, got left %0d right %0d seq %0d",
                   want.left_drive, want.right_drive, want.sequence_res,
                   got.left_drive, got.right_drive, got.sequence_res);
      end
    endfunction

    function int pending();
      return drive_queue.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  drive_mix_scoreboard sb;
  stall_t stall_mode = STALL_NONE;
  int     pairs_sent = 0;
  int     settings   = 1;   // reset defaults count as the first setting
  int     run_left   = 0;
  logic   run_ready  = 1'b1;

  joystick_differential_drive_mixer_core #(
    .SAMPLES(GROUP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns period, rising edges on odd nanoseconds
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side: always ready, alternating ready/stall runs, or scattered stalls
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_ready = ~run_ready;
          run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 8);
        end
        run_left--;
        out_ready <= run_ready;
      end
      STALL_SCATTER: out_ready <= ($urandom_range(0, 2) != 0);
      default:       out_ready <= 1'b1;
    endcase
  end

  // every accepted result beat goes straight to the checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic logic [SAMPLE_W-1:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  // level of an axis for one group; edge aims just around the deadzone threshold
  function automatic logic [SAMPLE_W-1:0] pick_level(spread_t kind, logic [SAMPLE_W-1:0] centre,
                                                      int dz);
    int v;
    int side;
    side = ($urandom_range(0, 1) != 0) ? 1 : -1;
    case (kind)
      SPREAD_NEAR: v = int'(centre) + int'($urandom_range(0, 800)) - 400;
      SPREAD_RAIL: v = (side > 0) ? SAMPLE_MAX - int'($urandom_range(0, 3))
                                  : int'($urandom_range(0, 3));
      SPREAD_EDGE: v = int'(centre) + side * (dz * 16 + int'($urandom_range(0, 40)) - 20);
      default:     v = $urandom_range(0, SAMPLE_MAX);
    endcase
    return clip_sample(v);
  endfunction

  // one input beat; valid is left high so the next beat can follow at once
  task automatic send_pair(in_t pair);
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(pair);
    pairs_sent++;
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // a whole group of pairs; step adds a small ramp so the floor of the average shows
  task automatic send_steady_group(int sx, int sy, int step);
    in_t pair;
    for (int k = 0; k < GROUP; k++) begin
      pair.sample_x = clip_sample(sx + step * (k % 3));
      pair.sample_y = clip_sample(sy + step * ((k + 1) % 3));
      send_pair(pair);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.configure(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every owed packet has come, then let the pipe settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // new register setting, then random groups with optional bursts and gaps
  task automatic run_phase(int dz, int cx, int cy, int expo, bit bursty, stall_t stall);
    in_t                 pair;
    spread_t             kind_x;
    spread_t             kind_y;
    logic [SAMPLE_W-1:0] lvl_x;
    logic [SAMPLE_W-1:0] lvl_y;
    int                  burst_left;
    // narrow registers get junk in the upper data bits, which must be dropped
    write_reg(CFG_DEADZONE, CFG_DATA_W'(($urandom << DEADZONE_W) | dz));
    write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
    write_reg(CFG_EXPO_ENABLE, CFG_DATA_W'(($urandom << 1) | expo));
    // index past the register list, ignored
    write_reg(CFG_IDX_W'($urandom_range(4, (1 << CFG_IDX_W) - 1)), CFG_DATA_W'($urandom));
    settings++;
    stall_mode = stall;
    burst_left = $urandom_range(1, 40);
    for (int g = 0; g < PHASE_GROUPS; g++) begin
      kind_x = spread_t'($urandom_range(0, 3));
      kind_y = spread_t'($urandom_range(0, 3));
      lvl_x  = pick_level(kind_x, sb.center_x, int'(sb.deadzone));
      lvl_y  = pick_level(kind_y, sb.center_y, int'(sb.deadzone));
      for (int k = 0; k < GROUP; k++) begin
        if (bursty && burst_left <= 0) begin
          pause_input($urandom_range(1, 6));
          burst_left = $urandom_range(1, 40);
        end
        pair.sample_x = (kind_x == SPREAD_FULL) ? SAMPLE_W'($urandom)
                                                : clip_sample(int'(lvl_x) + $urandom_range(0, 3));
        pair.sample_y = (kind_y == SPREAD_FULL) ? SAMPLE_W'($urandom)
                                                : clip_sample(int'(lvl_y) + $urandom_range(0, 3));
        send_pair(pair);
        burst_left--;
      end
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed groups at reset settings, back to back: rails, rest, cross corners,
    // and a ramp just around the deadzone threshold
    send_steady_group(0, 0, 0);
    send_steady_group(SAMPLE_MAX, SAMPLE_MAX, 0);
    send_steady_group(2048, 2048, 0);
    send_steady_group(SAMPLE_MAX, 0, 0);
    send_steady_group(0, SAMPLE_MAX, 0);
    send_steady_group(2209, 1886, 1);
    in_valid <= 1'b0;
    wait_drained();

    // register extremes first, then random settings
    run_phase(0, 2048, 2048, 0, 1'b0, STALL_NONE);
    run_phase(127, 2048, 2048, 1, 1'b1, STALL_RUNS);
    run_phase(0, 0, SAMPLE_MAX, 1, 1'b1, STALL_SCATTER);
    run_phase(1, SAMPLE_MAX, 0, 0, 1'b0, STALL_RUNS);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(0, 127), $urandom_range(0, SAMPLE_MAX),
                $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 1),
                p[0], stall_t'(p % 3));

    $display("sent %0d sample pairs, checked %0d drive beats across %0d register settings",
             pairs_sent, sb.results, settings);
    $display("failures: %0d, packets still owed: %0d", sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
